// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CWFP_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cwfp check failed");

// Next-cycle implication, disabled during reset.
`define CWFP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cwfp check failed");

`endif

// ===== rtl/core/cwfp_pkg.sv =====
`default_nettype none
package cwfp_pkg;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned NumPts   = 4;
  localparam int unsigned NumDets  = 4;
  localparam int unsigned NumLanes = 2 * NumDets;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned MagW     = CoordW;
  localparam int unsigned ProdW    = 2 * MagW;
  localparam int unsigned DetW     = ProdW + 3;
  localparam int unsigned DetMagW  = ProdW + 1;
  localparam int unsigned LoW      = 33;
  localparam int unsigned HiW      = DetMagW - LoW;
  localparam int unsigned RadW     = 2 * DetMagW;
  localparam int unsigned RootW    = DetMagW;
  localparam int unsigned RemW     = RootW + 1;
  localparam int unsigned NumShift = 15;
  localparam int unsigned NumW     = DetMagW + NumShift;
  localparam int unsigned QW       = 32;
  localparam int unsigned WeightW  = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 2 * CoordW * NumPts;

  // Determinant columns: td, t0, t1, t2 (points B0, B1, B2, P = 0..3)
  localparam int unsigned DetA [NumDets] = '{0, 3, 0, 0};
  localparam int unsigned DetB [NumDets] = '{1, 1, 3, 1};
  localparam int unsigned DetC [NumDets] = '{2, 2, 2, 3};

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StCollinear = 2'd1;
  localparam logic [StatusW-1:0] StZeroRoot  = 2'd2;
  localparam logic [StatusW-1:0] StSaturated = 2'd3;

  localparam logic [WeightW-1:0] WeightMax = 32'h7FFF_FFFF;
  localparam logic [WeightW-1:0] WeightMin = 32'h8000_0000;

  // Per-item flags that ride alongside the root and divider pipelines
  typedef struct packed {
    logic               tdz;
    logic               neg;
    logic [DetMagW-1:0] t1_mag;
  } cwfp_side_t;
endpackage
`default_nettype wire

// ===== rtl/core/cwfp_det.sv =====
`default_nettype none
// Three-stage determinant pipeline: differences, magnitude products, signed combine.
module cwfp_det (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [cwfp_pkg::InDataW-1:0]  coords_i,
  output logic                               valid_o,
  output logic [cwfp_pkg::DetW-1:0]          det_o [cwfp_pkg::NumDets]
);
  import cwfp_pkg::*;

  logic [DiffW-1:0] px [NumPts];
  logic [DiffW-1:0] py [NumPts];
  logic [DiffW-1:0] da_d [NumLanes];
  logic [DiffW-1:0] db_d [NumLanes];
  logic [DiffW-1:0] da_q [NumLanes];
  logic [DiffW-1:0] db_q [NumLanes];
  logic [DiffW-1:0] ma, mb;
  logic [ProdW-1:0] prod_d [NumLanes];
  logic [ProdW-1:0] prod_q [NumLanes];
  logic             sgn_d  [NumLanes];
  logic             sgn_q  [NumLanes];
  logic [DetW-1:0]  sp     [NumLanes];
  logic [DetW-1:0]  ext;
  logic [DetW-1:0]  det_d  [NumDets];
  logic             v1_q, v2_q, v3_q;

  // stage 1: sign-extended coordinate differences
  always_comb begin
    for (int p = 0; p < NumPts; p++) begin
      px[p] = {coords_i[2*CoordW*p + CoordW - 1], coords_i[2*CoordW*p +: CoordW]};
      py[p] = {coords_i[2*CoordW*p + 2*CoordW - 1], coords_i[2*CoordW*p + CoordW +: CoordW]};
    end
    for (int k = 0; k < NumDets; k++) begin
      da_d[2*k]   = px[DetB[k]] - px[DetA[k]];
      db_d[2*k]   = py[DetC[k]] - py[DetA[k]];
      da_d[2*k+1] = px[DetC[k]] - px[DetA[k]];
      db_d[2*k+1] = py[DetB[k]] - py[DetA[k]];
    end
  end

  // stage 2: 32x32 magnitude products
  always_comb begin
    ma = '0;
    mb = '0;
    for (int l = 0; l < NumLanes; l++) begin
      ma = da_q[l][DiffW-1] ? (~da_q[l] + 1'b1) : da_q[l];
      mb = db_q[l][DiffW-1] ? (~db_q[l] + 1'b1) : db_q[l];
      prod_d[l] = ma[MagW-1:0] * mb[MagW-1:0];
      sgn_d[l]  = da_q[l][DiffW-1] ^ db_q[l][DiffW-1];
    end
  end

  // stage 3: signed products and determinant
  always_comb begin
    ext = '0;
    for (int l = 0; l < NumLanes; l++) begin
      ext   = {{(DetW-ProdW){1'b0}}, prod_q[l]};
      sp[l] = sgn_q[l] ? (~ext + 1'b1) : ext;
    end
    for (int k = 0; k < NumDets; k++) begin
      det_d[k] = sp[2*k] - sp[2*k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      da_q   <= da_d;
      db_q   <= db_d;
      prod_q <= prod_d;
      sgn_q  <= sgn_d;
      det_o  <= det_d;
    end
  end

  assign valid_o = v3_q;
endmodule
`default_nettype wire

// ===== rtl/core/cwfp_root.sv =====
`default_nettype none
// |T0*T2| in partial products, then a one-bit-per-stage square root pipeline.
module cwfp_root (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [cwfp_pkg::DetW-1:0]  det_i [cwfp_pkg::NumDets],
  output logic                            valid_o,
  output logic [cwfp_pkg::RootW-1:0]      root_o,
  output cwfp_pkg::cwfp_side_t            side_o
);
  import cwfp_pkg::*;

  logic [DetW-1:0]      abs0, abs1, abs2;
  logic [DetMagW-1:0]   a_q, b_q;
  cwfp_side_t           side_a_d, side_a_q, side_b_q, side_c_q;
  logic [2*LoW-1:0]     pll_q, pll_c_q;
  logic [LoW+HiW-1:0]   plh_q, phl_q;
  logic [2*HiW-1:0]     phh_q, phh_c_q;
  logic [LoW+HiW:0]     cross_q;
  logic                 va_q, vb_q, vc_q;

  logic [RadW-1:0]      rad_q  [RootW+1];
  logic [RemW-1:0]      rem_q  [RootW+1];
  logic [RootW-1:0]     rt_q   [RootW+1];
  cwfp_side_t           sd_q   [RootW+1];
  logic                 v_q    [RootW+1];

  // stage A: magnitudes and item flags
  always_comb begin
    abs0 = det_i[1][DetW-1] ? (~det_i[1] + 1'b1) : det_i[1];
    abs1 = det_i[2][DetW-1] ? (~det_i[2] + 1'b1) : det_i[2];
    abs2 = det_i[3][DetW-1] ? (~det_i[3] + 1'b1) : det_i[3];
    side_a_d.tdz    = (det_i[0] == '0);
    side_a_d.neg    = det_i[0][DetW-1] ^ det_i[2][DetW-1];
    side_a_d.t1_mag = abs1[DetMagW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      vc_q   <= 1'b0;
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      va_q   <= valid_i;
      vb_q   <= va_q;
      vc_q   <= vb_q;
      v_q[0] <= vc_q;
    end
  end

  // stages A-D: partial products, cross sum, radicand
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= abs0[DetMagW-1:0];
      b_q      <= abs2[DetMagW-1:0];
      side_a_q <= side_a_d;
      pll_q    <= a_q[LoW-1:0] * b_q[LoW-1:0];
      plh_q    <= a_q[LoW-1:0] * b_q[DetMagW-1:LoW];
      phl_q    <= a_q[DetMagW-1:LoW] * b_q[LoW-1:0];
      phh_q    <= a_q[DetMagW-1:LoW] * b_q[DetMagW-1:LoW];
      side_b_q <= side_a_q;
      cross_q  <= {1'b0, plh_q} + {1'b0, phl_q};
      pll_c_q  <= pll_q;
      phh_c_q  <= phh_q;
      side_c_q <= side_b_q;
      rad_q[0] <= {phh_c_q, pll_c_q} + {{(RadW-LoW-LoW-HiW-1){1'b0}}, cross_q, {LoW{1'b0}}};
      rem_q[0] <= '0;
      rt_q[0]  <= '0;
      sd_q[0]  <= side_c_q;
    end
  end

  // square root: one result bit per stage, two radicand bits consumed
  for (genvar i = 0; i < RootW; i++) begin : g_sqrt
    localparam int unsigned J = RootW - 1 - i;
    logic [RemW+1:0] cur, trial;
    logic            ge;

    always_comb begin
      cur   = {rem_q[i], rad_q[i][2*J+1 -: 2]};
      trial = {1'b0, rt_q[i], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i+1] <= rad_q[i];
        sd_q[i+1]  <= sd_q[i];
        rem_q[i+1] <= ge ? RemW'(cur - trial) : cur[RemW-1:0];
        rt_q[i+1]  <= {rt_q[i][RootW-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[RootW];
  assign root_o  = rt_q[RootW];
  assign side_o  = sd_q[RootW];
endmodule
`default_nettype wire

// ===== rtl/core/cwfp_div.sv =====
`default_nettype none
// Restoring divider (one quotient bit a stage) and result formatting.
module cwfp_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [cwfp_pkg::RootW-1:0]  root_i,
  input  wire cwfp_pkg::cwfp_side_t        side_i,
  output logic                             valid_o,
  output logic [cwfp_pkg::WeightW-1:0]     weight_o,
  output logic [cwfp_pkg::StatusW-1:0]     status_o
);
  import cwfp_pkg::*;

  localparam int unsigned HiNumW = NumW - QW;

  logic [NumW-1:0]     num;
  logic [RootW-1:0]    dv_q   [QW+1];
  logic [RootW-1:0]    rm_q   [QW+1];
  logic [QW-1:0]       lo_q   [QW+1];
  logic [QW-1:0]       q_q    [QW+1];
  logic                ovf_q  [QW+1];
  logic                rz_q   [QW+1];
  cwfp_side_t          sd_q   [QW+1];
  logic                v_q    [QW+1];
  logic [WeightW-1:0]  weight_d;
  logic [StatusW-1:0]  status_d;
  logic                vo_q;

  assign num = {side_i.t1_mag, {NumShift{1'b0}}};

  // entry: quotient of 2^32 or more saturates in either sign
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q[0]  <= root_i;
      rm_q[0]  <= {{(RootW-HiNumW){1'b0}}, num[NumW-1:QW]};
      lo_q[0]  <= num[QW-1:0];
      q_q[0]   <= '0;
      ovf_q[0] <= ({{(RootW-HiNumW){1'b0}}, num[NumW-1:QW]} >= root_i);
      rz_q[0]  <= (root_i == '0);
      sd_q[0]  <= side_i;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RootW:0] cur;
    logic           ge;

    always_comb begin
      cur = {rm_q[j], lo_q[j][QW-1-j]};
      ge  = (cur >= {1'b0, dv_q[j]});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1]  <= dv_q[j];
        lo_q[j+1]  <= lo_q[j];
        ovf_q[j+1] <= ovf_q[j];
        rz_q[j+1]  <= rz_q[j];
        sd_q[j+1]  <= sd_q[j];
        rm_q[j+1]  <= ge ? RootW'(cur - {1'b0, dv_q[j]}) : cur[RootW-1:0];
        q_q[j+1]   <= {q_q[j][QW-2:0], ge};
      end
    end
  end

  // status priority: collinear, zero root, saturation
  always_comb begin
    weight_d = '0;
    status_d = StOk;
    if (sd_q[QW].tdz) begin
      status_d = StCollinear;
    end else if (rz_q[QW]) begin
      status_d = StZeroRoot;
    end else if (!sd_q[QW].neg) begin
      if (ovf_q[QW] || q_q[QW] > WeightMax) begin
        status_d = StSaturated;
        weight_d = WeightMax;
      end else begin
        weight_d = q_q[QW];
      end
    end else begin
      if (ovf_q[QW] || q_q[QW] > WeightMin) begin
        status_d = StSaturated;
        weight_d = WeightMin;
      end else begin
        weight_d = ~q_q[QW] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      weight_o <= weight_d;
      status_o <= status_d;
    end
  end

  assign valid_o = vo_q;
endmodule
`default_nettype wire

// ===== rtl/core/cwfp_skid.sv =====
`default_nettype none
`include "assert_macros.svh"
// Output register plus skid register; upstream ready is registered.
module cwfp_skid (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      valid_i,
  output logic                                           ready_o,
  input  wire logic [cwfp_pkg::WeightW+cwfp_pkg::StatusW-1:0] data_i,
  output logic                                           valid_o,
  input  wire logic                                      ready_i,
  output logic [cwfp_pkg::WeightW+cwfp_pkg::StatusW-1:0] data_o
);
  import cwfp_pkg::*;

  localparam int unsigned DW = WeightW + StatusW;

  logic          out_valid_q, skid_valid_q;
  logic [DW-1:0] out_data_q, skid_data_q;
  logic          take;

  assign take    = out_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (valid_i) begin
      if (out_valid_q && !ready_i) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (valid_i) begin
      if (out_valid_q && !ready_i) begin
        skid_data_q <= data_i;
      end else begin
        out_data_q <= data_i;
      end
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  `CWFP_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `CWFP_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_valid_q && ready_i, !skid_valid_q && out_valid_q)
endmodule
`default_nettype wire

// ===== rtl/core/conic_weight_from_passing_point.sv =====
// Middle weight of a rational quadratic conic through a given point.
// Input stream: one transaction carries B0, B1, B2 and the passing point P,
// all signed Q16.16. Output stream: one transaction per input with the
// middle weight in signed Q16.16 (tdata) and a status code (tuser):
// ok, collinear control points, zero root or saturated.
// Throughput: one transaction per cycle while s_axis_tready is high; the
// depth comes from the 65-stage square root and the 32-stage divider.
// The whole pipeline advances on one enable, which is the registered
// s_axis_tready: it drops only when the output register and the skid
// register are both full, so a stalled receiver never loses or repeats
// a transaction and the pipeline resumes as soon as the skid drains.
// Reset clears every valid bit; no result is pending after reset, and the
// block holds no state between transactions.
`default_nettype none
`include "assert_macros.svh"
module conic_weight_from_passing_point (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // first_x, first_y, middle_x, middle_y, last_x, last_y, pass_x, pass_y
  input  wire logic [cwfp_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // middle_weight
  output logic [cwfp_pkg::WeightW-1:0]           m_axis_tdata,
  // status
  output logic [cwfp_pkg::StatusW-1:0]           m_axis_tuser
);
  import cwfp_pkg::*;

  logic               en;
  logic               det_valid, root_valid, div_valid;
  logic [DetW-1:0]    det [NumDets];
  logic [RootW-1:0]   root;
  cwfp_side_t         side;
  logic [WeightW-1:0] weight;
  logic [StatusW-1:0] status;

  assign s_axis_tready = en;

  cwfp_det u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .coords_i(s_axis_tdata),
    .valid_o (det_valid),
    .det_o   (det)
  );

  cwfp_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (det_valid),
    .det_i   (det),
    .valid_o (root_valid),
    .root_o  (root),
    .side_o  (side)
  );

  cwfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (root_valid),
    .root_i  (root),
    .side_i  (side),
    .valid_o (div_valid),
    .weight_o(weight),
    .status_o(status)
  );

  cwfp_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid),
    .ready_o (en),
    .data_i  ({status, weight}),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  ({m_axis_tuser, m_axis_tdata})
  );

  `CWFP_ASSERT_IMPL(a_flag_zero_weight, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser == StCollinear || m_axis_tuser == StZeroRoot), m_axis_tdata == '0)
  `CWFP_ASSERT_IMPL(a_sat_extreme, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == StSaturated, m_axis_tdata == WeightMax || m_axis_tdata == WeightMin)
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cwfp_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [191:0]        big_t;

  typedef struct packed {
    logic signed [31:0] pass_y;
    logic signed [31:0] pass_x;
    logic signed [31:0] last_y;
    logic signed [31:0] last_x;
    logic signed [31:0] middle_y;
    logic signed [31:0] middle_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_x;
  } conic_pts_t;

  typedef struct packed {
    logic [WeightW-1:0] weight;
    logic [StatusW-1:0] status;
  } weight_res_t;

  typedef enum int {
    GenFull, GenSmall, GenOnCurve, GenCollinear, GenAtCtrl, GenNearMiddle
  } gen_kind_e;

  localparam int NumRandom = 1725;
  localparam int HoldAt    = 400;   // results seen before the long receiver hold
  localparam int HoldLen   = 400;
  localparam int PauseAt   = 1000;  // items sent before the sender drains
  localparam int TailCyc   = 250;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // first_x, first_y, middle_x, middle_y, last_x, last_y, pass_x, pass_y
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // middle_weight
  logic [WeightW-1:0] m_axis_tdata;
  // status
  logic [StatusW-1:0] m_axis_tuser;

  conic_pts_t  pending_pts[$];
  weight_res_t weights_due[$];

  logic in_fire = 1'b0;
  int   sent_cnt = 0, got_cnt = 0, err_cnt = 0, cyc_cnt = 0;
  int   send_gap = 0, recv_stall = 0, hold_left = 0;
  bit   hold_done = 1'b0, pause_done = 1'b0;
  int   status_seen[4] = '{0, 0, 0, 0};

  conic_weight_from_passing_point u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #1 clk_i = ~clk_i;

  // determinant of columns (a, b, c) over rows x, y, 1
  function automatic wide_t tri_det(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                                    wide_t cx, wide_t cy);
    return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
  endfunction

  function automatic big_t floor_sqrt(big_t n);
    big_t r, t;
    r = '0;
    for (int k = 190; k >= 0; k -= 2) begin
      t = r | (big_t'(1) << k);
      if (n >= t) begin
        n = n - t;
        r = (r >> 1) | (big_t'(1) << k);
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic weight_res_t conic_weight(conic_pts_t p);
    wide_t ax, ay, bx, by, cx, cy, px, py, td, t0, t1, t2;
    big_t m0, m2, m1, root, q;
    weight_res_t r;
    bit neg;
    ax = p.first_x;  ay = p.first_y;
    bx = p.middle_x; by = p.middle_y;
    cx = p.last_x;   cy = p.last_y;
    px = p.pass_x;   py = p.pass_y;
    td = tri_det(ax, ay, bx, by, cx, cy);
    t0 = tri_det(px, py, bx, by, cx, cy);
    t1 = tri_det(ax, ay, px, py, cx, cy);
    t2 = tri_det(ax, ay, bx, by, px, py);
    r.weight = '0;
    r.status = StOk;
    if (td == 0) begin
      r.status = StCollinear;
      return r;
    end
    m0 = big_t'(t0 < 0 ? -t0 : t0);
    m2 = big_t'(t2 < 0 ? -t2 : t2);
    m1 = big_t'(t1 < 0 ? -t1 : t1);
    root = floor_sqrt(m0 * m2);
    if (root == 0) begin
      r.status = StZeroRoot;
      return r;
    end
    neg = (td < 0) != (t1 < 0);
    q = (m1 << NumShift) / root;
    if (!neg) begin
      if (q > big_t'(32'h7FFF_FFFF)) begin
        r.status = StSaturated; r.weight = WeightMax;
      end else begin
        r.weight = q[31:0];
      end
    end else begin
      if (q > big_t'(32'h8000_0000)) begin
        r.status = StSaturated; r.weight = WeightMin;
      end else begin
        r.weight = -q[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] rnd_small();
    return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
  endfunction

  function automatic conic_pts_t make_pts(gen_kind_e kind);
    conic_pts_t p;
    logic signed [31:0] k, dx, dy;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (kind)
      GenFull: ;
      GenSmall: begin
        p = {rnd_small(), rnd_small(), rnd_small(), rnd_small(),
             rnd_small(), rnd_small(), rnd_small(), rnd_small()};
      end
      GenOnCurve: begin
        // parabola midpoint, weight near one
        p.first_x = rnd_small(); p.first_y = rnd_small();
        p.middle_x = rnd_small(); p.middle_y = rnd_small();
        p.last_x = rnd_small(); p.last_y = rnd_small();
        p.pass_x = (p.first_x + 2 * p.middle_x + p.last_x) >>> 2;
        p.pass_y = (p.first_y + 2 * p.middle_y + p.last_y) >>> 2;
      end
      GenCollinear: begin
        p.first_x = rnd_small(); p.first_y = rnd_small();
        dx = $signed($urandom_range(0, 4096)) - 2048;
        dy = $signed($urandom_range(0, 4096)) - 2048;
        k = $signed($urandom_range(0, 8)) - 4;
        p.last_x = p.first_x + dx; p.last_y = p.first_y + dy;
        p.middle_x = p.first_x + k * dx; p.middle_y = p.first_y + k * dy;
      end
      GenAtCtrl: begin
        case ($urandom_range(0, 2))
          0: begin p.pass_x = p.first_x;  p.pass_y = p.first_y;  end
          1: begin p.pass_x = p.middle_x; p.pass_y = p.middle_y; end
          default: begin p.pass_x = p.last_x; p.pass_y = p.last_y; end
        endcase
      end
      default: begin
        // passing point just off the middle control point: huge weights
        p.pass_x = p.middle_x + $signed($urandom_range(0, 6)) - 3;
        p.pass_y = p.middle_y + $signed($urandom_range(0, 6)) - 3;
      end
    endcase
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((cyc_cnt / 600) % 4 == 0) return 0;  // burst stretch, no idling
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sample both handshakes, predict and check
  always @(posedge clk_i) begin
    weight_res_t exp_r;
    cyc_cnt <= cyc_cnt + 1;
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cnt++;
      if (weights_due.size() == 0) begin
        $error("unexpected result weight=%h status=%0d", m_axis_tdata, m_axis_tuser);
        err_cnt++;
      end else begin
        exp_r = weights_due.pop_front();
        status_seen[exp_r.status]++;
        if (m_axis_tdata !== exp_r.weight) begin
          $error("middle_weight: expected %h, got %h", exp_r.weight, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
          err_cnt++;
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      weights_due.push_back(conic_weight(conic_pts_t'(s_axis_tdata)));
  end

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !s_axis_tvalid)) begin
      if (!pause_done && sent_cnt >= PauseAt) begin
        s_axis_tvalid <= 1'b0;
        if (weights_due.size() == 0) pause_done <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pts.size() > 0) begin
        s_axis_tdata <= pending_pts.pop_front();
        s_axis_tvalid <= 1'b1;
        sent_cnt <= sent_cnt + 1;
        send_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off so the pipeline backs up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && got_cnt >= HoldAt) begin
        hold_done <= 1'b1;
        hold_left <= HoldLen;
        m_axis_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall <= pick_gap();
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    conic_pts_t p;
    gen_kind_e kind;
    int r;
    // unit triangle (0,0) (1,1) (2,0), P on the parabola midpoint: weight one
    p = '{pass_y: 32'h0000_8000, pass_x: 32'h0001_0000, last_y: 0, last_x: 32'h0002_0000,
          middle_y: 32'h0001_0000, middle_x: 32'h0001_0000, first_y: 0, first_x: 0};
    pending_pts.push_back(p);
    p.pass_y = -32'sh0000_8000;  // negative weight
    pending_pts.push_back(p);
    p.pass_y = 0;                // numerator zero
    pending_pts.push_back(p);
    pending_pts.push_back('0);   // all collinear
    pending_pts.push_back('1);
    pending_pts.push_back({8{32'h7FFF_FFFF}});
    pending_pts.push_back({8{32'h8000_0000}});
    // extreme corners
    p = '{pass_y: 32'h7FFF_FFFF, pass_x: 32'h8000_0000, last_y: 32'h8000_0000,
          last_x: 32'h7FFF_FFFF, middle_y: 32'h7FFF_FFFF, middle_x: 32'h7FFF_FFFF,
          first_y: 32'h8000_0000, first_x: 32'h8000_0000};
    pending_pts.push_back(p);
    p.pass_x = 32'h7FFF_FFFF; p.pass_y = 32'h7FFF_FFFF;  // on B1, zero root
    pending_pts.push_back(p);
    p.pass_x = 32'h7FFF_FFFE;                           // next to B1, saturates
    pending_pts.push_back(p);
    p.pass_x = 32'h8000_0000; p.pass_y = 32'h8000_0000; // on B0
    pending_pts.push_back(p);
    p = '{pass_y: 32'h8000_0000, pass_x: 32'h7FFF_FFFF, last_y: 32'h7FFF_FFFF,
          last_x: 32'h8000_0000, middle_y: 32'h8000_0000, middle_x: 32'h8000_0000,
          first_y: 32'h7FFF_FFFF, first_x: 32'h7FFF_FFFF};
    pending_pts.push_back(p);
    for (int i = 0; i < 4; i++) pending_pts.push_back(make_pts(GenNearMiddle));
    for (int i = 0; i < 3; i++) pending_pts.push_back(make_pts(GenAtCtrl));
    for (int i = 0; i < 3; i++) pending_pts.push_back(make_pts(GenCollinear));
    // random mix
    for (int i = 0; i < NumRandom; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) kind = GenFull;
      else if (r < 50) kind = GenSmall;
      else if (r < 70) kind = GenOnCurve;
      else if (r < 80) kind = GenCollinear;
      else if (r < 88) kind = GenAtCtrl;
      else kind = GenNearMiddle;
      pending_pts.push_back(make_pts(kind));
    end

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // check at rising edges, where the driven inputs are settled
    do @(posedge clk_i);
    while (pending_pts.size() != 0 || s_axis_tvalid || weights_due.size() != 0);
    repeat (TailCyc) @(posedge clk_i);
    $display("covered %0d items: %0d ok, %0d collinear, %0d zero root, %0d saturated",
             sent_cnt, status_seen[StOk], status_seen[StCollinear],
             status_seen[StZeroRoot], status_seen[StSaturated]);
    $display("with a %0d-cycle output hold-off and a full drain mid-run", HoldLen);
    if (err_cnt == 0 && weights_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== conic_weight_from_passing_point.f =====
+incdir+rtl/core
rtl/core/cwfp_pkg.sv
rtl/core/cwfp_det.sv
rtl/core/cwfp_root.sv
rtl/core/cwfp_div.sv
rtl/core/cwfp_skid.sv
rtl/core/conic_weight_from_passing_point.sv
tb/sv/tb.sv
